FILE: design/desk_display_frame_decoder_macros.svh
// Assertion macros used by the frame decoder port checker.
`ifndef DESK_DISPLAY_FRAME_DECODER_MACROS_SVH
`define DESK_DISPLAY_FRAME_DECODER_MACROS_SVH

// Check a property on every rising edge outside reset.
`define DDFD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define DDFD_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
    `DDFD_ASSERT(label, clk, rst_n, (cond) |-> (cons), msg)

`endif

FILE: design/ddfd_pkg.sv
// Package with types, constants and helpers of the desk display frame decoder.
`default_nettype none

package ddfd_pkg;

    localparam int unsigned ACC_W   = 13;
    localparam int unsigned H_W     = 12;
    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned OUT_W   = 16;

    localparam logic [ACC_W-1:0] HEIGHT_SAT = 13'd4096;

    localparam logic [7:0] CH_OPEN  = 8'h3A;
    localparam logic [7:0] CH_CLOSE = 8'h3B;
    localparam logic [7:0] CH_CMD_D = 8'h44;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [H_W-1:0] MIN_RESET = 12'd200;
    localparam logic [H_W-1:0] MAX_RESET = 12'd1500;

    localparam logic REG_MIN = 1'b0;
    localparam logic REG_MAX = 1'b1;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_SHORT      = 3'd1,
        ST_BAD_HEX    = 3'd2,
        ST_CHECKSUM   = 3'd3,
        ST_OTHER_CMD  = 3'd4,
        ST_BLANK      = 3'd5,
        ST_BAD_NUMBER = 3'd6,
        ST_RANGE      = 3'd7
    } t_status;

    typedef struct packed {
        logic done;
        logic extra;
        logic bad;
        logic frac;
        logic point;
        logic digit;
    } t_num_flags;

    // Bit 4 set marks a character that is no hex digit.
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b0, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b0, 4'(c - 8'h57)};
        end
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: design/ddfd_height_step.sv
// One character step of the decimal height parser.
`default_nettype none

module ddfd_height_step #(
    parameter int unsigned MAX_HEIGHT_CHARS = 15,
    parameter int unsigned HC_W             = 4
) (
    input  wire logic                      i_en,
    input  wire logic [7:0]                i_char,
    input  wire logic [ddfd_pkg::ACC_W-1:0] i_acc,
    input  wire ddfd_pkg::t_num_flags      i_flags,
    input  wire logic [HC_W-1:0]           i_count,
    output logic [ddfd_pkg::ACC_W-1:0]     o_acc,
    output ddfd_pkg::t_num_flags           o_flags,
    output logic [HC_W-1:0]                o_count
);
    import ddfd_pkg::*;

    logic        w_skip;
    logic        w_is_digit;
    logic [3:0]  w_d;
    logic [16:0] w_int_sum;
    logic [16:0] w_frac_sum;

    always_comb begin
        w_skip     = i_flags.done || (i_count >= HC_W'(MAX_HEIGHT_CHARS));
        w_is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
        w_d        = 4'(i_char - CH_ZERO);
        w_int_sum  = {1'b0, i_acc, 3'b000} + {3'b000, i_acc, 1'b0}
                   + {10'd0, w_d, 3'b000} + {12'd0, w_d, 1'b0};
        w_frac_sum = {4'd0, i_acc} + {13'd0, w_d};

        o_acc   = i_acc;
        o_flags = i_flags;
        o_count = i_count;
        if (i_en && !w_skip) begin
            if (i_char == CH_COMMA) begin
                o_flags.done = 1'b1;
            end else begin
                o_count = i_count + HC_W'(1);
                if (w_is_digit) begin
                    o_flags.digit = 1'b1;
                    if (!i_flags.point) begin
                        o_acc = (w_int_sum > {4'd0, HEIGHT_SAT}) ? HEIGHT_SAT
                                                                 : w_int_sum[ACC_W-1:0];
                    end else if (!i_flags.frac) begin
                        o_acc = (w_frac_sum > {4'd0, HEIGHT_SAT}) ? HEIGHT_SAT
                                                                  : w_frac_sum[ACC_W-1:0];
                        o_flags.frac = 1'b1;
                    end else if (w_d != 4'd0) begin
                        o_flags.extra = 1'b1;
                    end
                end else if (i_char == CH_POINT && !i_flags.point) begin
                    o_flags.point = 1'b1;
                end else begin
                    o_flags.bad = 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/desk_display_frame_decoder.sv
// Bytes enter an input register; a frame's result goes to a result register.
// Throughput: one byte per cycle; the input register stalls only while a
// result waits in the output register and m_axis_tready is low.
// Reset (synchronous, active low): frame state, flags and valids clear,
// height limits return to 200 and 1500 tenths of a centimeter.
`default_nettype none

module desk_display_frame_decoder #(
    parameter int unsigned MAX_BODY         = 31,
    parameter int unsigned MAX_HEIGHT_CHARS = 15
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ddfd_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [ddfd_pkg::DATA_W-1:0]   pwdata,
    output logic [ddfd_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [2:0] frame_status, [14:3] height_tenths, [15] ack_request
    output logic [ddfd_pkg::OUT_W-1:0]         m_axis_tdata
);
    import ddfd_pkg::*;

    localparam int unsigned BC_W = $clog2(MAX_BODY + 1);
    localparam int unsigned HC_W = $clog2(MAX_HEIGHT_CHARS + 1);

    logic [H_W-1:0]   r_min;
    logic [H_W-1:0]   r_max;

    logic             r_in_valid;
    logic [7:0]       r_in_byte;

    logic             r_in_frame,  n_in_frame;
    logic [BC_W-1:0]  r_body_count, n_body_count;
    logic [7:0]       r_pend0,     n_pend0;
    logic [7:0]       r_pend1,     n_pend1;
    logic [7:0]       r_sum,       n_sum;
    logic [7:0]       r_cmd,       n_cmd;
    logic [ACC_W-1:0] r_acc,       n_acc;
    t_num_flags       r_flags,     n_flags;
    logic [HC_W-1:0]  r_hcount,    n_hcount;

    logic             r_out_valid;
    t_status          r_out_status;
    logic [H_W-1:0]   r_out_height;

    logic             w_adv;
    logic             w_emit;
    logic             w_commit;
    logic             w_feed;
    t_status          w_status;
    logic [4:0]       w_hi;
    logic [4:0]       w_lo;
    logic [ACC_W-1:0] w_step_acc;
    t_num_flags       w_step_flags;
    logic [HC_W-1:0]  w_step_count;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = {{(DATA_W-H_W){1'b0}}, (paddr[2] == REG_MAX) ? r_max : r_min};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= MIN_RESET;
            r_max <= MAX_RESET;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_MAX) begin
                r_max <= pwdata[H_W-1:0];
            end else begin
                r_min <= pwdata[H_W-1:0];
            end
        end
    end

    // Input register
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // Frame close evaluation
    always_comb begin
        w_hi = hex_nibble(r_pend0);
        w_lo = hex_nibble(r_pend1);
        if (r_body_count < BC_W'(3)) begin
            w_status = ST_SHORT;
        end else if (w_hi[4] || w_lo[4]) begin
            w_status = ST_BAD_HEX;
        end else if ({w_hi[3:0], w_lo[3:0]} != r_sum) begin
            w_status = ST_CHECKSUM;
        end else if (r_cmd != CH_CMD_D) begin
            w_status = ST_OTHER_CMD;
        end else if (r_body_count < BC_W'(4) || r_hcount == '0) begin
            w_status = ST_BLANK;
        end else if (r_flags.bad || !r_flags.digit) begin
            w_status = ST_BAD_NUMBER;
        end else if (r_acc < {1'b0, r_min} || r_acc > {1'b0, r_max}
                     || (r_acc == {1'b0, r_max} && r_flags.extra)) begin
            w_status = ST_RANGE;
        end else begin
            w_status = ST_OK;
        end
    end

    // Body character flow
    assign w_commit = r_in_frame && r_in_byte != CH_OPEN && r_in_byte != CH_CLOSE
                      && r_body_count < BC_W'(MAX_BODY) && r_body_count >= BC_W'(2);
    assign w_feed   = w_commit && r_body_count != BC_W'(2);
    assign w_emit   = r_in_frame && r_in_byte == CH_CLOSE;

    ddfd_height_step #(
        .MAX_HEIGHT_CHARS (MAX_HEIGHT_CHARS),
        .HC_W             (HC_W)
    ) u_height (
        .i_en    (w_feed),
        .i_char  (r_pend0),
        .i_acc   (r_acc),
        .i_flags (r_flags),
        .i_count (r_hcount),
        .o_acc   (w_step_acc),
        .o_flags (w_step_flags),
        .o_count (w_step_count)
    );

    always_comb begin
        n_in_frame   = r_in_frame;
        n_body_count = r_body_count;
        n_pend0      = r_pend0;
        n_pend1      = r_pend1;
        n_sum        = r_sum;
        n_cmd        = r_cmd;
        n_acc        = w_step_acc;
        n_flags      = w_step_flags;
        n_hcount     = w_step_count;
        if (r_in_byte == CH_OPEN) begin
            n_in_frame   = 1'b1;
            n_body_count = '0;
            n_sum        = '0;
            n_acc        = '0;
            n_flags      = '0;
            n_hcount     = '0;
        end else if (r_in_frame) begin
            if (r_in_byte == CH_CLOSE) begin
                n_in_frame = 1'b0;
            end else if (r_body_count >= BC_W'(MAX_BODY)) begin
                n_in_frame = 1'b0;
            end else begin
                if (w_commit) begin
                    n_sum   = r_sum + r_pend0;
                    n_pend0 = r_pend1;
                    n_pend1 = r_in_byte;
                    if (r_body_count == BC_W'(2)) begin
                        n_cmd = r_pend0;
                    end
                end else if (r_body_count == '0) begin
                    n_pend0 = r_in_byte;
                end else begin
                    n_pend1 = r_in_byte;
                end
                n_body_count = r_body_count + BC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_body_count <= '0;
            r_sum        <= '0;
            r_acc        <= '0;
            r_flags      <= '0;
            r_hcount     <= '0;
        end else if (w_adv) begin
            r_in_frame   <= n_in_frame;
            r_body_count <= n_body_count;
            r_sum        <= n_sum;
            r_acc        <= n_acc;
            r_flags      <= n_flags;
            r_hcount     <= n_hcount;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pend0 <= n_pend0;
            r_pend1 <= n_pend1;
            r_cmd   <= n_cmd;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_out_status <= w_status;
            r_out_height <= (w_status == ST_OK) ? r_acc[H_W-1:0] : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_status == ST_OK, r_out_height, r_out_status};

endmodule

`default_nettype wire

FILE: design/ddfd_checker.sv
// Port-level checker for the desk display frame decoder and its bind.
`default_nettype none

`include "desk_display_frame_decoder_macros.svh"

module ddfd_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        pready,
    input wire logic                        m_axis_tvalid,
    input wire logic                        m_axis_tready,
    input wire logic [ddfd_pkg::OUT_W-1:0]  m_axis_tdata
);
    import ddfd_pkg::*;

    `DDFD_ASSERT(a_pready_high, i_clk, i_rst_n, pready, "pready dropped")
    `DDFD_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    `DDFD_ASSERT_IMPL(a_ack_ok, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[15] == (m_axis_tdata[2:0] == ST_OK), "ack does not match status")
    `DDFD_ASSERT_IMPL(a_height_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[2:0] != ST_OK, m_axis_tdata[14:3] == '0, "height set on failed frame")

endmodule

bind desk_display_frame_decoder ddfd_checker u_ddfd_checker (.*);

`default_nettype wire

FILE: dv/ddfd_frame_checker.sv
// Checker that predicts frame reports from accepted bytes and compares them.
`default_nettype none

module ddfd_frame_checker #(
    parameter int unsigned MAX_BODY         = 31,
    parameter int unsigned MAX_HEIGHT_CHARS = 15
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_psel,
    input  wire logic                        i_penable,
    input  wire logic                        i_pwrite,
    input  wire logic                        i_pready,
    input  wire logic [ddfd_pkg::ADDR_W-1:0] i_paddr,
    input  wire logic [ddfd_pkg::DATA_W-1:0] i_pwdata,
    input  wire logic                        i_byte_valid,
    input  wire logic                        i_byte_ready,
    input  wire logic [7:0]                  i_byte_data,
    input  wire logic                        i_report_valid,
    input  wire logic                        i_report_ready,
    input  wire logic [ddfd_pkg::OUT_W-1:0]  i_report_data,
    output int                               o_fail_count,
    output int                               o_pending
);
    import ddfd_pkg::*;

    localparam logic [ADDR_W-1:0] ADDR_LO = {REG_MIN, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_HI = {REG_MAX, 2'b00};
    localparam int unsigned BC_W = $clog2(MAX_BODY + 1);
    localparam int unsigned HC_W = $clog2(MAX_HEIGHT_CHARS + 1);

    typedef struct packed {
        logic           ack;
        logic [H_W-1:0] height;
        t_status        status;
    } t_report;

    t_report       expected_reports[$];
    int            mismatches = 0;
    int            waiting = 0;

    logic [H_W-1:0]   lim_lo;
    logic [H_W-1:0]   lim_hi;
    logic             in_frame;
    logic [BC_W-1:0]  body_cnt;
    logic [7:0]       held[2];
    logic [7:0]       run_sum;
    logic [7:0]       cmd;
    logic [ACC_W-1:0] acc;
    t_num_flags       flags;
    logic [HC_W-1:0]  num_chars;

    assign o_fail_count = mismatches;
    assign o_pending    = waiting;

    function automatic int hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        return 16;
    endfunction

    task automatic take_height_char(input logic [7:0] c);
        int v;
        int d;
        if (flags.done || num_chars >= MAX_HEIGHT_CHARS) return;
        if (c == CH_COMMA) begin
            flags.done = 1'b1;
            return;
        end
        num_chars++;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = int'(c) - int'(CH_ZERO);
            flags.digit = 1'b1;
            if (!flags.point) begin
                v = int'(acc) * 10 + 10 * d;
                acc = (v > int'(HEIGHT_SAT)) ? HEIGHT_SAT : ACC_W'(v);
            end else if (!flags.frac) begin
                v = int'(acc) + d;
                acc = (v > int'(HEIGHT_SAT)) ? HEIGHT_SAT : ACC_W'(v);
                flags.frac = 1'b1;
            end else if (d != 0) begin
                flags.extra = 1'b1;
            end
        end else if (c == CH_POINT && !flags.point) begin
            flags.point = 1'b1;
        end else begin
            flags.bad = 1'b1;
        end
    endtask

    function automatic t_report close_report();
        t_report r;
        int      hi;
        int      lo;
        r.status = ST_OK;
        r.height = '0;
        r.ack    = 1'b0;
        hi = hex_value(held[0]);
        lo = hex_value(held[1]);
        if (body_cnt < 3) begin
            r.status = ST_SHORT;
        end else if (hi > 15 || lo > 15) begin
            r.status = ST_BAD_HEX;
        end else if (8'(hi * 16 + lo) != run_sum) begin
            r.status = ST_CHECKSUM;
        end else if (cmd != CH_CMD_D) begin
            r.status = ST_OTHER_CMD;
        end else if (body_cnt < 4 || num_chars == 0) begin
            r.status = ST_BLANK;
        end else if (flags.bad || !flags.digit) begin
            r.status = ST_BAD_NUMBER;
        end else if (acc < {1'b0, lim_lo} || acc > {1'b0, lim_hi}
                     || (acc == {1'b0, lim_hi} && flags.extra)) begin
            r.status = ST_RANGE;
        end else begin
            r.height = acc[H_W-1:0];
            r.ack    = 1'b1;
        end
        return r;
    endfunction

    task automatic decode_byte(input logic [7:0] c);
        if (c == CH_OPEN) begin
            in_frame  = 1'b1;
            body_cnt  = '0;
            run_sum   = '0;
            acc       = '0;
            flags     = '0;
            num_chars = '0;
        end else if (!in_frame) begin
            return;
        end else if (c == CH_CLOSE) begin
            in_frame = 1'b0;
            expected_reports.push_back(close_report());
        end else if (body_cnt >= MAX_BODY) begin
            in_frame = 1'b0;
        end else begin
            if (body_cnt >= 2) begin
                run_sum = run_sum + held[0];
                if (body_cnt == 2) begin
                    cmd = held[0];
                end else begin
                    take_height_char(held[0]);
                end
                held[0] = held[1];
                held[1] = c;
            end else begin
                held[body_cnt[0]] = c;
            end
            body_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_report got;
        t_report want;
        if (!i_rst_n) begin
            lim_lo    = MIN_RESET;
            lim_hi    = MAX_RESET;
            in_frame  = 1'b0;
            body_cnt  = '0;
            held[0]   = '0;
            held[1]   = '0;
            run_sum   = '0;
            cmd       = '0;
            acc       = '0;
            flags     = '0;
            num_chars = '0;
            expected_reports.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == ADDR_LO) begin
                    lim_lo = i_pwdata[H_W-1:0];
                end else if (i_paddr == ADDR_HI) begin
                    lim_hi = i_pwdata[H_W-1:0];
                end
            end
            if (i_report_valid && i_report_ready) begin
                got = t_report'(i_report_data);
                if (expected_reports.size() == 0) begin
                    $display("%0t unexpected frame report: expected none, got %h",
                             $time, i_report_data);
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t frame_status: expected %0d, got %0d",
                                 $time, want.status, got.status);
                        mismatches++;
                    end
                    if (got.height !== want.height) begin
                        $display("%0t height_tenths: expected %0d, got %0d",
                                 $time, want.height, got.height);
                        mismatches++;
                    end
                    if (got.ack !== want.ack) begin
                        $display("%0t ack_request: expected %0d, got %0d",
                                 $time, want.ack, got.ack);
                        mismatches++;
                    end
                end
            end
            if (i_byte_valid && i_byte_ready) begin
                decode_byte(i_byte_data);
            end
        end
        waiting = expected_reports.size();
    end

endmodule

`default_nettype wire

FILE: dv/tb_desk_display_frame_decoder.sv
// Testbench top that drives serial bytes and limit writes into the frame decoder.
`default_nettype none

module tb_desk_display_frame_decoder;
    import ddfd_pkg::*;

    localparam logic [ADDR_W-1:0] ADDR_LO = {REG_MIN, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_HI = {REG_MAX, 2'b00};
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 400;
    localparam int SETTLE         = 8;

    typedef logic [7:0] t_bytes[$];

    logic              i_clk;
    logic              i_rst_n       = 1'b0;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [ADDR_W-1:0] paddr         = '0;
    logic [DATA_W-1:0] pwdata        = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;

    int fails;
    int pending;
    int idle_odds     = 4;
    bit long_hold_req = 1'b0;
    int bytes_sent    = 0;
    int idle_count    = 0;
    int cur_lo        = int'(MIN_RESET);
    int cur_hi        = int'(MAX_RESET);

    desk_display_frame_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ddfd_frame_checker report_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_byte_valid   (s_axis_tvalid),
        .i_byte_ready   (s_axis_tready),
        .i_byte_data    (s_axis_tdata),
        .i_report_valid (m_axis_tvalid),
        .i_report_ready (m_axis_tready),
        .i_report_data  (m_axis_tdata),
        .o_fail_count   (fails),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
        end
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("FAIL desk_display_frame_decoder");
            $finish;
        end
    end

    // Receiver: random stalls, one long hold-off on request.
    initial begin
        forever begin
            if (long_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    function automatic t_bytes text(input string s);
        t_bytes q;
        foreach (s[i]) q.push_back(s[i]);
        return q;
    endfunction

    function automatic t_bytes random_bytes(input int n);
        t_bytes q;
        repeat (n) q.push_back(8'($urandom_range(0, 255)));
        return q;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 10) return CH_ZERO + 8'(n);
        return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    function automatic t_bytes height_body();
        t_bytes q;
        t_bytes junk;
        int     tenths;
        int     pick;
        string  s;
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
            tenths = ($urandom_range(0, 1) ? cur_lo : cur_hi) + $urandom_range(0, 4) - 2;
            if (tenths < 0) tenths = 0;
        end else if (pick < 8) begin
            tenths = $urandom_range(cur_lo, cur_hi);
        end else begin
            tenths = $urandom_range(0, 50000);
        end
        s = $sformatf("%0d", tenths / 10);
        if ($urandom_range(0, 4) == 0) s = {"00", s};
        if (tenths % 10 != 0 || $urandom_range(0, 1)) begin
            s = $sformatf("%s.%0d", s, tenths % 10);
            if ($urandom_range(0, 3) == 0) s = $sformatf("%s%0d", s, $urandom_range(0, 99));
        end
        if ($urandom_range(0, 4) == 0) s = $sformatf("%s,%0d", s, $urandom_range(0, 999));
        q = text({"D", s});
        if ($urandom_range(0, 9) == 0) begin
            junk = text(" +-eExnNi.");
            junk.push_back(8'h00);
            q[$urandom_range(1, q.size() - 1)] = junk[$urandom_range(0, junk.size() - 1)];
        end
        return q;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic send_all(input t_bytes q);
        foreach (q[i]) send_byte(q[i]);
    endtask

    // Frame the body and append its checksum; a nonzero skew forces a mismatch.
    task automatic send_frame(input t_bytes body, input int skew, input bit lower);
        logic [7:0] cs;
        cs = 8'(skew);
        foreach (body[i]) cs = cs + body[i];
        send_byte(CH_OPEN);
        send_all(body);
        send_byte(hex_char(cs[7:4], lower));
        send_byte(hex_char(cs[3:0], lower));
        send_byte(CH_CLOSE);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_frame();
        t_bytes body;
        int     pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            send_frame(height_body(), ($urandom_range(0, 19) == 0) ? $urandom_range(1, 255) : 0,
                       $urandom_range(0, 1));
        end else if (pick < 80) begin
            body = random_bytes($urandom_range(0, 8));
            body.push_front(8'($urandom_range(8'h41, 8'h5A)));
            send_frame(body, 0, $urandom_range(0, 1));
        end else if (pick < 88) begin
            body = random_bytes($urandom_range(0, 12));
            body.push_front(CH_OPEN);
            body.push_back(CH_CLOSE);
            send_all(body);
        end else if (pick < 94) begin
            send_all(random_bytes($urandom_range(1, 5)));
        end else if (pick < 97) begin
            send_byte(CH_OPEN);
            repeat ($urandom_range(30, 40)) send_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
            send_byte(CH_CLOSE);
        end else begin
            send_all(text(":D1"));
            send_frame(height_body(), 0, 1'b0);
        end
    endtask

    task automatic run_phase(input int lo, input int hi, input int odds, input bit hold,
                             input int nbytes);
        int stop;
        drain();
        apb_write(ADDR_LO, lo);
        apb_write(ADDR_HI, hi);
        cur_lo        = lo;
        cur_hi        = hi;
        idle_odds     = odds;
        long_hold_req = hold;
        stop = bytes_sent + nbytes;
        while (bytes_sent < stop) random_frame();
    endtask

    initial begin
        t_bytes nul_body;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset limits of 200 and 1500 tenths.
        send_all(text(";x"));
        send_frame(text("D123.4"), 0, 1'b0);
        send_frame(text("D20"), 0, 1'b1);
        send_frame(text("D150"), 0, 1'b0);
        send_frame(text("D150.01"), 0, 1'b0);
        send_frame(text("D150.00"), 0, 1'b1);
        send_frame(text("D19.9"), 0, 1'b0);
        send_frame(text("D99999"), 0, 1'b0);
        send_all(text(":;:a;:ab;:D12zz;:D12g0;"));
        send_frame(text("D120"), 1, 1'b0);
        send_frame(text("X50"), 0, 1'b0);
        send_frame(text("D"), 0, 1'b0);
        send_frame(text("D,5"), 0, 1'b0);
        send_frame(text("D-5"), 0, 1'b0);
        send_frame(text("D1e2"), 0, 1'b0);
        send_frame(text("D 12"), 0, 1'b0);
        send_frame(text("Dinf"), 0, 1'b0);
        send_frame(text("D0x1F"), 0, 1'b0);
        send_frame(text("D1.2.3"), 0, 1'b0);
        send_frame(text("D."), 0, 1'b0);
        nul_body = text("D1");
        nul_body.push_back(8'h00);
        send_frame(nul_body, 0, 1'b0);
        send_frame(text("D100,xyz"), 0, 1'b0);
        send_frame(text("D000000000000100xyz"), 0, 1'b0);
        send_all(text(":D"));
        repeat (35) send_byte(CH_NINE);
        send_byte(CH_CLOSE);
        send_all(text(":D12"));
        send_frame(text("D130.5"), 0, 1'b0);

        run_phase(0, 4095, 4, 1'b1, 180);
        run_phase(4095, 0, 3, 1'b0, 130);
        run_phase(0, 0, 0, 1'b0, 130);
        run_phase(4095, 4095, 6, 1'b0, 130);
        run_phase($urandom_range(0, 2000), $urandom_range(1000, 4095), 4, 1'b0, 200);
        run_phase(int'(MIN_RESET), int'(MAX_RESET), 0, 1'b0, 220);
        drain();

        if (fails == 0 && pending == 0) begin
            $display("PASS desk_display_frame_decoder");
        end else begin
            $display("FAIL desk_display_frame_decoder");
        end
        $finish;
    end

endmodule

`default_nettype wire
